// File: hw/rtl/rcc_pkg.sv
// Shared types and constants for the route cost and capacity checker.
`default_nettype none

package rcc_pkg;

  localparam int CAPACITY_BITS = 24;
  localparam int NODE_BITS     = 7;
  localparam int INDEX_BITS    = 6;
  localparam int VALUE_BITS    = 16;
  localparam int TOTAL_BITS    = 32;
  localparam int CMD_BITS      = 2;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [CMD_BITS-1:0] CMD_COST_WR   = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_DEMAND_WR = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_ROUTE     = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEPOT    = 1'd1;

  localparam logic [CAPACITY_BITS-1:0] CAPACITY_RESET = 24'd22000;
  localparam logic [NODE_BITS-1:0]     DEPOT_RESET    = 7'd1;

  localparam logic [CAPACITY_BITS-1:0] LOAD_MAX = '1;
  localparam logic [TOTAL_BITS-1:0]    COST_MAX = '1;

  // control carried alongside the table read data
  typedef struct packed {
    logic route;
    logic last;
    logic depot;
    logic node_ok;
    logic prev_ok;
  } stage_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/route_cost_capacity_check.sv
// A route's last node goes through the table read stage, then the result register.
// Throughput: one request per cycle while req_stall is low; the edge cost and
// demand tables are each read once per cycle, and the running load/cost update is
// combinational. Reset clears the running load, cost, overload flag and pipeline
// valids, and restores capacity to 22000 and the depot node to 1. The cost and
// demand tables are not cleared: an entry is undefined until it has been written.
`default_nettype none

module route_cost_capacity_check
  import rcc_pkg::*;
#(
  parameter int NODE_COUNT = 64,
  parameter int COST_BITS  = 16
) (
  input  wire                       clk,
  input  wire                       rst,

  input  wire                       cfg_we,
  input  wire [CFG_IDX_BITS-1:0]    cfg_index,
  input  wire [CAPACITY_BITS-1:0]   cfg_data,

  input  wire                       req_valid,
  output logic                      req_stall,
  input  wire [CMD_BITS-1:0]        cmd,
  input  wire [INDEX_BITS-1:0]      row_node,
  input  wire [INDEX_BITS-1:0]      col_node,
  input  wire [VALUE_BITS-1:0]      entry_value,
  input  wire [NODE_BITS-1:0]       route_node,
  input  wire                       last_node,

  output logic                      res_valid,
  input  wire                       res_stall,
  output logic [TOTAL_BITS-1:0]     total_cost,
  output logic                      valid_res
);

  localparam int NB = $clog2(NODE_COUNT);
  localparam int EB = $clog2(NODE_COUNT * NODE_COUNT);
  localparam logic [EB-1:0] NC_E = EB'(NODE_COUNT);
  localparam logic [31:0]   NC_W = 32'(NODE_COUNT);

  // configuration
  logic [CAPACITY_BITS-1:0] capacity;
  logic [NODE_BITS-1:0]     depot_node;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAPACITY_RESET;
      depot_node <= DEPOT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAPACITY: capacity   <= cfg_data;
        REG_DEPOT:    depot_node <= cfg_data[NODE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control: everything moves unless a result is waiting and stalled
  logic advance;
  logic req_take;

  assign advance   = !res_valid || !res_stall;
  assign req_stall = !advance;
  assign req_take  = req_valid && advance;

  // front end: previous node tracking and table addressing
  logic                 route_start;
  logic [NODE_BITS-1:0] prev_node;
  logic [NODE_BITS-1:0] prev_eff;
  logic [NODE_BITS-1:0] prev_m1;
  logic [NODE_BITS-1:0] node_m1;
  logic                 is_route;
  logic                 node_ok;
  logic                 prev_ok;
  logic                 row_ok;
  logic                 col_ok;
  logic                 cost_we;
  logic                 demand_we;
  logic [EB-1:0]        cost_wr_addr;
  logic [EB-1:0]        cost_rd_addr;
  logic [NB-1:0]        demand_wr_addr;
  logic [NB-1:0]        demand_rd_addr;

  assign is_route = (cmd == CMD_ROUTE);
  assign prev_eff = route_start ? depot_node : prev_node;
  assign prev_m1  = prev_eff - 7'd1;
  assign node_m1  = route_node - 7'd1;
  assign node_ok  = (route_node != '0) && (32'(route_node) <= NC_W);
  assign prev_ok  = (prev_eff != '0) && (32'(prev_eff) <= NC_W);
  assign row_ok   = 32'(row_node) < NC_W;
  assign col_ok   = 32'(col_node) < NC_W;

  assign cost_we   = req_take && (cmd == CMD_COST_WR) && row_ok && col_ok;
  assign demand_we = req_take && (cmd == CMD_DEMAND_WR) && row_ok;

  assign cost_wr_addr   = EB'(row_node) * NC_E + EB'(col_node);
  assign cost_rd_addr   = EB'(prev_m1) * NC_E + EB'(node_m1);
  assign demand_wr_addr = NB'(row_node);
  assign demand_rd_addr = NB'(node_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      route_start <= 1'b1;
      prev_node   <= DEPOT_RESET;
    end else if (req_take && is_route) begin
      route_start <= last_node;
      prev_node   <= route_node;
    end
  end

  // tables
  logic [COST_BITS-1:0]  edge_mem   [0:NODE_COUNT*NODE_COUNT-1];
  logic [VALUE_BITS-1:0] demand_mem [0:NODE_COUNT-1];
  logic [COST_BITS-1:0]  cost_q;
  logic [VALUE_BITS-1:0] demand_q;

  always_ff @(posedge clk) begin
    if (cost_we) begin
      edge_mem[cost_wr_addr] <= COST_BITS'(entry_value);
    end
    if (req_take && is_route) begin
      cost_q <= edge_mem[cost_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (demand_we) begin
      demand_mem[demand_wr_addr] <= entry_value;
    end
    if (req_take && is_route) begin
      demand_q <= demand_mem[demand_rd_addr];
    end
  end

  // stage after the table read
  logic       a_valid;
  stage_ctl_t a_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= req_take && is_route;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      a_ctl.route   <= is_route;
      a_ctl.last    <= last_node;
      a_ctl.depot   <= (route_node == depot_node);
      a_ctl.node_ok <= node_ok;
      a_ctl.prev_ok <= prev_ok;
    end
  end

  // running load and cost
  logic [CAPACITY_BITS-1:0] running_load;
  logic [TOTAL_BITS-1:0]    running_cost;
  logic                     overload_seen;
  logic [CAPACITY_BITS-1:0] running_load_next;
  logic [TOTAL_BITS-1:0]    running_cost_next;
  logic                     overload_next;
  logic [VALUE_BITS-1:0]    demand_add;
  logic [TOTAL_BITS-1:0]    edge_add;
  logic [CAPACITY_BITS:0]   load_sum;
  logic [TOTAL_BITS:0]      cost_sum;
  logic                     a_fire;

  assign a_fire     = advance && a_valid && a_ctl.route;
  assign demand_add = a_ctl.node_ok ? demand_q : '0;
  assign edge_add   = (a_ctl.node_ok && a_ctl.prev_ok) ? TOTAL_BITS'(cost_q) : '0;
  assign load_sum   = {1'b0, running_load} + (CAPACITY_BITS+1)'(demand_add);
  assign cost_sum   = {1'b0, running_cost} + {1'b0, edge_add};

  always_comb begin
    overload_next     = overload_seen || (running_load > capacity);
    running_load_next = running_load;
    running_cost_next = running_cost;
    if (a_ctl.depot) begin
      running_load_next = '0;
    end else begin
      running_load_next = load_sum[CAPACITY_BITS] ? LOAD_MAX : load_sum[CAPACITY_BITS-1:0];
      running_cost_next = cost_sum[TOTAL_BITS] ? COST_MAX : cost_sum[TOTAL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_load  <= '0;
      running_cost  <= '0;
      overload_seen <= 1'b0;
    end else if (a_fire) begin
      if (a_ctl.last) begin
        // route done: rearm for the next one
        running_load  <= '0;
        running_cost  <= '0;
        overload_seen <= 1'b0;
      end else begin
        running_load  <= running_load_next;
        running_cost  <= running_cost_next;
        overload_seen <= overload_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= a_fire && a_ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && a_ctl.last) begin
      total_cost <= overload_next ? '0 : running_cost_next;
      valid_res  <= !overload_next;
    end
  end

  // checks
  a_rejected_cost_zero : assert property (@(posedge clk) disable iff (rst)
    res_valid && !valid_res |-> total_cost == '0)
    else $error("invalid route result carries nonzero cost");

  a_result_from_last : assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(res_valid) |-> $past(a_valid && a_ctl.route && a_ctl.last))
    else $error("result raised without a last route node");

  a_rearm_after_last : assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(a_fire && a_ctl.last)
      |-> running_load == '0 && running_cost == '0 && !overload_seen)
    else $error("running state not rearmed after last node");

  a_hold_on_stall : assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(a_valid && !advance) |-> a_valid && $stable(demand_q) && $stable(cost_q))
    else $error("read stage changed while stalled");

endmodule

`default_nettype wire
